@@ hdl/caster_encoder_odometry_core_macros.svh @@
// Assertion macros for the caster encoder odometry core.
`ifndef CASTER_ENCODER_ODOMETRY_CORE_MACROS_SVH
`define CASTER_ENCODER_ODOMETRY_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define CEO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CEO_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CEO_ASSERT(lbl, clk, rst_n, prop, msg)
`define CEO_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ hdl/ceo_pkg.sv @@
`default_nettype none
package ceo_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_CPT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TPC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IWB = 2'd2;

    localparam logic [14:0] CPT_RESET = 15'd4096;
    localparam logic [23:0] IWB_RESET = 24'd65536;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_IDX_W = $clog2(CORDIC_STEPS);
    localparam int CW           = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam int MUL_W     = 34;
    localparam int MUL_CNT_W = $clog2(MUL_W);
    localparam int PROD_W    = 2 * MUL_W;
    localparam logic signed [MUL_W-1:0] RAD_TO_BAM = 34'sd683565276;

    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_STEER   = 2'd0,
        OP_ROT     = 2'd1,
        OP_TICK    = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic signed [15:0] count;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic signed [15:0] half_heading_sin;
        logic signed [15:0] half_heading_cos;
        logic signed [15:0] steer_angle;
        logic               pose_updated;
    } t_result;

    function automatic logic [29:0] atan_lut(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -72'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    function automatic logic signed [15:0] clamp14(input logic signed [CW-1:0] v);
        logic signed [15:0] r;
        if (v > 34'sd16384) begin
            r = 16'sd16384;
        end else if (v < -34'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/ceo_if.sv @@
`default_nettype none
interface ceo_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [15:0] count;
    modport source (output valid, output opcode, output count, input ready);
    modport sink (input valid, input opcode, input count, output ready);
endinterface

interface ceo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [15:0] half_heading_sin;
    logic signed [15:0] half_heading_cos;
    logic signed [15:0] steer_angle;
    logic               pose_updated;
    modport source (output valid, output pos_x, output pos_y, output heading,
                    output half_heading_sin, output half_heading_cos,
                    output steer_angle, output pose_updated, input ready);
    modport sink (input valid, input pos_x, input pos_y, input heading,
                  input half_heading_sin, input half_heading_cos,
                  input steer_angle, input pose_updated, output ready);
endinterface
`default_nettype wire

@@ hdl/caster_encoder_odometry_core.sv @@
// Channel  Dir  Handshake      Payload
// i_in     in   valid / ready  opcode[1:0], count[15:0] signed
// o_out    out  valid / ready  pos_x, pos_y, heading, half_heading_sin/cos,
//                              steer_angle, pose_updated
// i_cfg    in   i_cfg_we       i_cfg_idx[1:0], i_cfg_data[31:0]
// Per item the back end runs: steer items a 32-step divider plus one CORDIC pass;
// rotation, restart and unseeded tick items one CORDIC pass; seeded ticks seven
// 34-step serial multiplies and three 16-step CORDIC passes on one shared unit each.
// Synchronous active-low reset; no clearing pass.
// A two-entry input queue keeps accepting items until full while the back end works or a
// result waits in the output register.
`default_nettype none
`include "caster_encoder_odometry_core_macros.svh"
module caster_encoder_odometry_core import ceo_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ceo_in_if.sink                i_in,
    ceo_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    q_valid;
    t_item   q_item;
    logic    q_take;
    t_q_stat q_stat;
    t_result res;
    logic    res_valid;
    logic    bk_busy;

    ceo_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_take  (q_take),
        .o_stat  (q_stat)
    );

    ceo_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_take    (q_take),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (o_out.ready),
        .o_busy      (bk_busy)
    );

    assign o_out.valid            = res_valid;
    assign o_out.pos_x            = res.pos_x;
    assign o_out.pos_y            = res.pos_y;
    assign o_out.heading          = res.heading;
    assign o_out.half_heading_sin = res.half_heading_sin;
    assign o_out.half_heading_cos = res.half_heading_cos;
    assign o_out.steer_angle      = res.steer_angle;
    assign o_out.pose_updated     = res.pose_updated;

    `CEO_ASSERT_NEVER(a_q_full_empty, i_clk, i_rst_n, q_stat.full && q_stat.empty, "queue full and empty")
    `CEO_ASSERT(a_out_from_work, i_clk, i_rst_n, $rose(o_out.valid) |-> $past(bk_busy), "result without work")

endmodule
`default_nettype wire

@@ hdl/ceo_front.sv @@
`default_nettype none
module ceo_front import ceo_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ceo_in_if.sink  i_in,
    output logic    o_valid,
    output t_item   o_item,
    input  logic    i_take,
    output t_q_stat o_stat
);

    t_item                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wp;
    logic [Q_PTR_W-1:0]   r_rp;
    logic [Q_CNT_W-1:0]   r_cnt;
    logic                 push;
    logic                 pop;
    t_item                item_in;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign i_in.ready   = !o_stat.full;
    assign o_valid      = !o_stat.empty;
    assign o_item       = r_mem[r_rp];
    assign push         = i_in.valid && i_in.ready;
    assign pop          = o_valid && i_take;

    always_comb begin
        item_in.op    = t_op'(i_in.opcode);
        item_in.count = i_in.count;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= item_in;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/ceo_mul.sv @@
`default_nettype none
module ceo_mul import ceo_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic                     o_done,
    output logic signed [PROD_W-1:0] o_p
);

    logic                  r_busy;
    logic                  r_done;
    logic [MUL_CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0]     r_acc;
    logic [MUL_W-1:0]      r_mcand;
    logic                  r_neg;
    logic [MUL_W:0]        sum;
    logic [MUL_W-1:0]      mag_a;
    logic [MUL_W-1:0]      mag_b;

    always_comb begin
        mag_a = i_a[MUL_W-1] ? MUL_W'(-i_a) : MUL_W'(i_a);
        mag_b = i_b[MUL_W-1] ? MUL_W'(-i_b) : MUL_W'(i_b);
        sum   = {1'b0, r_acc[PROD_W-1:MUL_W]} + (r_acc[0] ? {1'b0, r_mcand} : '0);
    end

    assign o_done = r_done;
    assign o_p    = r_neg ? -$signed(r_acc) : $signed(r_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_acc   <= {{MUL_W{1'b0}}, mag_b};
                r_mcand <= mag_a;
                r_neg   <= i_a[MUL_W-1] ^ i_b[MUL_W-1];
            end else if (r_busy) begin
                r_acc <= {sum, r_acc[MUL_W-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/ceo_cordic.sv @@
`default_nettype none
module ceo_cordic import ceo_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [31:0]          i_ang,
    output logic                 o_done,
    output logic signed [CW-1:0] o_c,
    output logic signed [CW-1:0] o_s
);

    logic                    r_busy;
    logic                    r_done;
    logic                    r_flip;
    logic [CORDIC_IDX_W-1:0] r_idx;
    logic signed [CW-1:0]    r_x;
    logic signed [CW-1:0]    r_y;
    logic signed [CW-1:0]    r_z;
    logic [31:0]             ang_off;
    logic                    flip;
    logic [31:0]             ang_f;
    logic signed [CW-1:0]    xs;
    logic signed [CW-1:0]    ys;
    logic signed [CW-1:0]    at;

    always_comb begin
        ang_off = i_ang + 32'h4000_0000;
        flip    = ang_off[31];
        ang_f   = flip ? (i_ang ^ 32'h8000_0000) : i_ang;
        xs      = r_x >>> r_idx;
        ys      = r_y >>> r_idx;
        at      = CW'(atan_lut(5'(r_idx)));
    end

    assign o_done = r_done;
    assign o_c    = r_flip ? -r_x : r_x;
    assign o_s    = r_flip ? -r_y : r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_flip <= flip;
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= CW'($signed(ang_f));
            end else if (r_busy) begin
                if (r_z >= 0) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
                r_idx <= r_idx + 1'b1;
                if (r_idx == CORDIC_IDX_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/ceo_back.sv @@
`default_nettype none
module ceo_back import ceo_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_q_valid,
    input  t_item                 i_q_item,
    output logic                  o_q_take,
    output t_result               o_res,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic                  o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_HALF,
        S_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        ST_DIST,
        ST_STEER,
        ST_SIDE,
        ST_FWD,
        ST_TH,
        ST_DTH,
        ST_MID,
        ST_X,
        ST_Y,
        ST_HALF
    } t_stage;

    t_state r_state;
    t_stage r_stage;

    logic [14:0]        r_cpt;
    logic [31:0]        r_tpc;
    logic [23:0]        r_iwb;

    logic [15:0]        r_steer;
    logic [15:0]        r_last;
    logic               r_seeded;
    logic [31:0]        r_total;
    logic [31:0]        r_total_tick;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic [15:0]        r_yaw;

    logic signed [31:0]    r_dist;
    logic signed [MUL_W-1:0] r_side;
    logic signed [MUL_W-1:0] r_fwd;
    logic [32:0]           r_dth;
    logic                  r_upd;
    logic signed [15:0]    r_hs;
    logic signed [15:0]    r_hc;

    logic [14:0]          r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_dcnt;
    logic                 r_dneg;

    logic                    r_mul_go;
    logic signed [MUL_W-1:0] r_ma;
    logic signed [MUL_W-1:0] r_mb;
    logic                    r_cor_go;
    logic [31:0]             r_ang;

    logic    r_ov;
    t_result r_res;

    logic                     mul_done;
    logic signed [PROD_W-1:0] mul_p;
    logic                     cor_done;
    logic signed [CW-1:0]     cor_c;
    logic signed [CW-1:0]     cor_s;

    logic [14:0]              cpt_eff;
    logic signed [16:0]       half_s;
    logic [15:0]              last_use;
    logic signed [16:0]       gap;
    logic [31:0]              tot_add;
    logic [31:0]              tot_next;
    logic [15:0]              rem_sh;
    logic                     ge;
    logic [14:0]              rem_nx;
    logic [DIV_W-1:0]         quo_nx;
    logic [15:0]              cnt_abs;
    logic [31:0]              d_diff;
    logic signed [PROD_W-1:0] p16;
    logic signed [PROD_W-1:0] p30;
    logic signed [31:0]       sat_p16;
    logic [32:0]              dth_now;
    logic [31:0]              yaw32;
    logic [31:0]              mid;
    logic [31:0]              yaw_sum;
    logic signed [31:0]       x_new;
    logic signed [31:0]       y_new;
    logic signed [CW-1:0]     hs_r;
    logic signed [CW-1:0]     hc_r;

    ceo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    ceo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cor_go),
        .i_ang   (r_ang),
        .o_done  (cor_done),
        .o_c     (cor_c),
        .o_s     (cor_s)
    );

    always_comb begin
        cpt_eff  = (r_cpt < 15'd2) ? 15'd2 : r_cpt;
        half_s   = $signed({3'b000, cpt_eff[14:1]});
        last_use = r_seeded ? r_last : i_q_item.count;
        gap      = 17'(i_q_item.count) - 17'($signed(last_use));
        tot_add  = r_total + 32'(gap);
        if (gap > half_s) begin
            tot_next = tot_add - {17'd0, cpt_eff};
        end else if (gap < -half_s) begin
            tot_next = tot_add + {17'd0, cpt_eff};
        end else begin
            tot_next = tot_add;
        end
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        ge      = (rem_sh >= {1'b0, cpt_eff});
        rem_nx  = ge ? 15'(rem_sh - {1'b0, cpt_eff}) : rem_sh[14:0];
        quo_nx  = {r_quo[DIV_W-2:0], ge};
        cnt_abs = i_q_item.count[15] ? 16'(-i_q_item.count) : i_q_item.count;
        d_diff  = r_total - r_total_tick;
        p16     = (mul_p + PROD_W'(32768)) >>> 16;
        p30     = (mul_p + PROD_W'(1 << 29)) >>> 30;
        sat_p16 = sat32(72'(p16));
        dth_now = 33'(p16);
        yaw32   = {r_yaw, 16'h0000};
        mid     = yaw32 + dth_now[32:1];
        yaw_sum = yaw32 + r_dth[31:0] + 32'h0000_8000;
        x_new   = sat32(72'(r_x) + 72'(p30));
        y_new   = sat32(72'(r_y) + 72'(p30));
        hs_r    = (cor_s + CW'(32768)) >>> 16;
        hc_r    = (cor_c + CW'(32768)) >>> 16;
    end

    assign o_q_take    = (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_res       = r_res;
    assign o_res_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_stage      <= ST_HALF;
            r_cpt        <= CPT_RESET;
            r_tpc        <= '0;
            r_iwb        <= IWB_RESET;
            r_steer      <= '0;
            r_last       <= '0;
            r_seeded     <= 1'b0;
            r_total      <= '0;
            r_total_tick <= '0;
            r_x          <= '0;
            r_y          <= '0;
            r_yaw        <= '0;
            r_mul_go     <= 1'b0;
            r_cor_go     <= 1'b0;
            r_ov         <= 1'b0;
            r_dcnt       <= '0;
        end else begin
            r_mul_go <= 1'b0;
            r_cor_go <= 1'b0;
            if (r_ov && i_res_ready && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CPT: r_cpt <= i_cfg_data[14:0];
                    CFG_TPC: r_tpc <= i_cfg_data;
                    CFG_IWB: r_iwb <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_upd <= (i_q_item.op == OP_TICK) && r_seeded;
                        unique case (i_q_item.op)
                            OP_STEER: begin
                                r_quo   <= {cnt_abs, 16'h0000};
                                r_rem   <= '0;
                                r_dcnt  <= '0;
                                r_dneg  <= i_q_item.count[15];
                                r_state <= S_DIV;
                            end
                            OP_ROT: begin
                                r_seeded <= 1'b1;
                                r_last   <= i_q_item.count;
                                r_total  <= tot_next;
                                r_state  <= S_HALF;
                            end
                            OP_TICK: begin
                                if (r_seeded) begin
                                    r_total_tick <= r_total;
                                    r_ma         <= -MUL_W'($signed(d_diff));
                                    r_mb         <= {2'b00, r_tpc};
                                    r_mul_go     <= 1'b1;
                                    r_stage      <= ST_DIST;
                                    r_state      <= S_WAIT;
                                end else begin
                                    r_state <= S_HALF;
                                end
                            end
                            OP_RESTART: begin
                                r_seeded     <= 1'b0;
                                r_total      <= '0;
                                r_total_tick <= '0;
                                r_x          <= '0;
                                r_y          <= '0;
                                r_yaw        <= '0;
                                r_state      <= S_HALF;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    r_rem  <= rem_nx;
                    r_quo  <= quo_nx;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DIV_CNT_W'(DIV_W - 1)) begin
                        r_steer <= r_dneg ? (16'd0 - quo_nx[15:0]) : quo_nx[15:0];
                        r_state <= S_HALF;
                    end
                end
                S_HALF: begin
                    r_ang    <= {r_yaw[15], r_yaw, 15'd0};
                    r_cor_go <= 1'b1;
                    r_stage  <= ST_HALF;
                    r_state  <= S_WAIT;
                end
                S_WAIT: begin
                    if (mul_done || cor_done) begin
                        unique case (r_stage)
                            ST_DIST: begin
                                r_dist   <= sat_p16;
                                r_ang    <= {r_steer, 16'h0000};
                                r_cor_go <= 1'b1;
                                r_stage  <= ST_STEER;
                            end
                            ST_STEER: begin
                                r_ma     <= MUL_W'(r_dist);
                                r_mb     <= cor_s;
                                r_mul_go <= 1'b1;
                                r_stage  <= ST_SIDE;
                            end
                            ST_SIDE: begin
                                r_side   <= MUL_W'(p30);
                                r_ma     <= MUL_W'(r_dist);
                                r_mb     <= cor_c;
                                r_mul_go <= 1'b1;
                                r_stage  <= ST_FWD;
                            end
                            ST_FWD: begin
                                r_fwd    <= MUL_W'(p30);
                                r_ma     <= r_side;
                                r_mb     <= {10'd0, r_iwb};
                                r_mul_go <= 1'b1;
                                r_stage  <= ST_TH;
                            end
                            ST_TH: begin
                                r_ma     <= MUL_W'(sat_p16);
                                r_mb     <= RAD_TO_BAM;
                                r_mul_go <= 1'b1;
                                r_stage  <= ST_DTH;
                            end
                            ST_DTH: begin
                                r_dth    <= dth_now;
                                r_ang    <= mid;
                                r_cor_go <= 1'b1;
                                r_stage  <= ST_MID;
                            end
                            ST_MID: begin
                                r_ma     <= r_fwd;
                                r_mb     <= cor_c;
                                r_mul_go <= 1'b1;
                                r_stage  <= ST_X;
                            end
                            ST_X: begin
                                r_x      <= x_new;
                                r_ma     <= r_fwd;
                                r_mb     <= cor_s;
                                r_mul_go <= 1'b1;
                                r_stage  <= ST_Y;
                            end
                            ST_Y: begin
                                r_y     <= y_new;
                                r_yaw   <= yaw_sum[31:16];
                                r_state <= S_HALF;
                            end
                            ST_HALF: begin
                                r_hs    <= clamp14(hs_r);
                                r_hc    <= clamp14(hc_r);
                                r_state <= S_OUT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_OUT: begin
                    if (!r_ov || i_res_ready) begin
                        r_res.pos_x            <= r_x;
                        r_res.pos_y            <= r_y;
                        r_res.heading          <= r_yaw;
                        r_res.half_heading_sin <= r_hs;
                        r_res.half_heading_cos <= r_hc;
                        r_res.steer_angle      <= r_steer;
                        r_res.pose_updated     <= r_upd;
                        r_ov                   <= 1'b1;
                        r_state                <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import ceo_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam longint CYCLE_LIMIT = 10000000;
    localparam longint RAD_TO_ANGLE = 683565276;
    localparam longint START_GAIN = 652032874;
    localparam longint ARCTAN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ceo_in_if in_ch();
    ceo_out_if out_ch();

    caster_encoder_odometry_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // odometry state mirror
    logic [14:0] cpt_reg;
    logic [31:0] travel_reg;
    logic [23:0] inv_wb_reg;
    logic [15:0] steer_st;
    logic [15:0] last_raw_st;
    logic        seeded_st;
    logic [31:0] total_st;
    logic [31:0] total_tick_st;
    logic [31:0] x_st;
    logic [31:0] y_st;
    logic [15:0] yaw_st;

    t_result pose_q[$];
    int      err_cnt;
    longint  cycle_cnt;
    int      stall_left;
    bit      busy_src;
    logic [15:0] sent_raw;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip_q14(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    function automatic void sin_cos(input logic [31:0] ang, output longint c,
                                    output longint s);
        logic [31:0] t;
        logic        flip;
        longint      x, y, z, xs, ys;
        t = ang + 32'h4000_0000;
        flip = t[31];
        if (flip) ang = ang ^ 32'h8000_0000;
        z = longint'(signed'(ang));
        x = START_GAIN;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - ARCTAN[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ARCTAN[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic void dead_reckon();
        longint d, travel, cs, sn, cm, sm, side, fwd, th, dth, yaw32;
        logic [31:0] mid;
        d = longint'(signed'(total_st - total_tick_st));
        travel = sat_word(rnd_shift(-d * longint'({32'b0, travel_reg}), 16));
        total_tick_st = total_st;
        sin_cos({steer_st, 16'b0}, cs, sn);
        side = rnd_shift(travel * sn, 30);
        fwd = rnd_shift(travel * cs, 30);
        th = sat_word(rnd_shift(side * longint'({40'b0, inv_wb_reg}), 16));
        dth = rnd_shift(th * RAD_TO_ANGLE, 16);
        yaw32 = longint'(signed'(yaw_st)) * 65536;
        mid = 32'(yaw32 + (dth >>> 1));
        sin_cos(mid, cm, sm);
        x_st = 32'(sat_word(longint'(signed'(x_st)) + rnd_shift(fwd * cm, 30)));
        y_st = 32'(sat_word(longint'(signed'(y_st)) + rnd_shift(fwd * sm, 30)));
        yaw_st = 16'((yaw32 + dth + 32768) >>> 16);
    endfunction

    function automatic t_result odometry_step(t_op op, logic [15:0] cnt_raw);
        t_result r;
        longint  cnt, cpt, half, gap, hc, hs;
        logic    upd;
        cnt = longint'(signed'(cnt_raw));
        cpt = (cpt_reg < 2) ? 2 : longint'(cpt_reg);
        upd = 1'b0;
        case (op)
            OP_STEER: steer_st = 16'((cnt * 65536) / cpt);
            OP_ROT: begin
                half = cpt / 2;
                if (!seeded_st) begin
                    last_raw_st = cnt_raw;
                    seeded_st = 1'b1;
                end
                gap = cnt - longint'(signed'(last_raw_st));
                last_raw_st = cnt_raw;
                total_st = total_st + 32'(gap);
                if (gap > half) total_st = total_st - 32'(cpt);
                else if (gap < -half) total_st = total_st + 32'(cpt);
            end
            OP_TICK: begin
                if (seeded_st) begin
                    dead_reckon();
                    upd = 1'b1;
                end
            end
            default: begin
                seeded_st = 1'b0;
                total_st = '0;
                total_tick_st = '0;
                x_st = '0;
                y_st = '0;
                yaw_st = '0;
            end
        endcase
        sin_cos(32'(longint'(signed'(yaw_st)) * 32768), hc, hs);
        r.pos_x = x_st;
        r.pos_y = y_st;
        r.heading = yaw_st;
        r.half_heading_sin = 16'(clip_q14(rnd_shift(hs, 16)));
        r.half_heading_cos = 16'(clip_q14(rnd_shift(hc, 16)));
        r.steer_angle = steer_st;
        r.pose_updated = upd;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            pose_q.push_back(odometry_step(t_op'(in_ch.opcode), in_ch.count));
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.pos_x = out_ch.pos_x;
            got.pos_y = out_ch.pos_y;
            got.heading = out_ch.heading;
            got.half_heading_sin = out_ch.half_heading_sin;
            got.half_heading_cos = out_ch.half_heading_cos;
            got.steer_angle = out_ch.steer_angle;
            got.pose_updated = out_ch.pose_updated;
            if (pose_q.size() == 0) begin
                $display("%0t: unexpected pose %p", $time, got);
                err_cnt++;
            end else begin
                want = pose_q.pop_front();
                if (got.pos_x !== want.pos_x) begin
                    $display("%0t: pos_x exp %0d got %0d", $time, want.pos_x, got.pos_x);
                    err_cnt++;
                end
                if (got.pos_y !== want.pos_y) begin
                    $display("%0t: pos_y exp %0d got %0d", $time, want.pos_y, got.pos_y);
                    err_cnt++;
                end
                if (got.heading !== want.heading) begin
                    $display("%0t: heading exp %0d got %0d", $time, want.heading,
                             got.heading);
                    err_cnt++;
                end
                if (got.half_heading_sin !== want.half_heading_sin) begin
                    $display("%0t: half_heading_sin exp %0d got %0d", $time,
                             want.half_heading_sin, got.half_heading_sin);
                    err_cnt++;
                end
                if (got.half_heading_cos !== want.half_heading_cos) begin
                    $display("%0t: half_heading_cos exp %0d got %0d", $time,
                             want.half_heading_cos, got.half_heading_cos);
                    err_cnt++;
                end
                if (got.steer_angle !== want.steer_angle) begin
                    $display("%0t: steer_angle exp %0d got %0d", $time,
                             want.steer_angle, got.steer_angle);
                    err_cnt++;
                end
                if (got.pose_updated !== want.pose_updated) begin
                    $display("%0t: pose_updated exp %0d got %0d", $time,
                             want.pose_updated, got.pose_updated);
                    err_cnt++;
                end
            end
        end
    end

    // stall the result side: mostly short, sometimes long, bursts of none
    always @(posedge i_clk) begin
        int pick;
        pick = $urandom_range(0, 99);
        if (!i_rst_n) begin
            out_ch.ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (busy_src) begin
            out_ch.ready <= 1'b1;
        end else if (pick < 3) begin
            out_ch.ready <= 1'b0;
            stall_left <= $urandom_range(20, 400);
        end else begin
            out_ch.ready <= (pick < 70);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (busy_src || p < 55) return 0;
        if (p < 92) return $urandom_range(1, 5);
        return $urandom_range(20, 200);
    endfunction

    task automatic send_item(t_op op, logic [15:0] cnt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.count <= cnt;
        if (op == OP_ROT) sent_raw = cnt;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CPT: cpt_reg = data[14:0];
            CFG_TPC: travel_reg = data;
            CFG_IWB: inv_wb_reg = data[23:0];
            default: ;
        endcase
    endtask

    task automatic test_unseeded_and_steer();
        send_item(OP_TICK, 16'h1234);
        send_item(OP_STEER, 16'h7FFF);
        send_item(OP_STEER, 16'h8000);
        send_item(OP_STEER, 16'h0400);
        send_item(OP_RESTART, 16'hFFFF);
    endtask

    task automatic test_unwrap_and_tick();
        write_reg(CFG_TPC, 32'hFFFF_FFFF);
        write_reg(CFG_IWB, 24'hFF_FFFF);
        send_item(OP_ROT, 16'h7FF0);
        send_item(OP_ROT, 16'h8010);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_ROT, 16'h7000);
        send_item(OP_ROT, 16'h0100);
        send_item(OP_ROT, 16'hF100);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_RESTART, 16'h0000);
        send_item(OP_TICK, 16'h0000);
    endtask

    task automatic test_small_turn_counts();
        write_reg(CFG_CPT, 32'hFFFF_0000);
        send_item(OP_STEER, 16'hFFFF);
        send_item(OP_ROT, 16'h0003);
        send_item(OP_ROT, 16'h0000);
        send_item(OP_TICK, 16'h0000);
        write_reg(CFG_CPT, 32'd1);
        send_item(OP_ROT, 16'h0002);
        write_reg(CFG_SPARE, 32'hDEAD_BEEF);
        write_reg(CFG_CPT, 32'd32767);
        send_item(OP_STEER, 16'h8000);
        send_item(OP_TICK, 16'h0000);
    endtask

    task automatic test_random_drive(int items);
        int     n, p, half;
        logic [15:0] delta;
        n = 0;
        while (n < items) begin
            if (n % 125 == 0) begin
                case ((n / 125) % 5)
                    0: write_reg(CFG_CPT, 32'($urandom_range(2, 32767)));
                    1: write_reg(CFG_CPT, 32'($urandom_range(0, 1)));
                    2: write_reg(CFG_TPC, $urandom());
                    3: write_reg(CFG_TPC, 32'($urandom_range(0, 1)) * 32'hFFFF_FFFF);
                    default: write_reg(CFG_IWB, $urandom());
                endcase
                if ($urandom_range(0, 2) == 0) write_reg(CFG_IWB, $urandom_range(0, 1) ?
                                                         32'hFF_FFFF : 32'd0);
                busy_src = ($urandom_range(0, 3) == 0);
                send_item(OP_RESTART, 16'($urandom()));
                send_item(OP_ROT, 16'($urandom()));
                n += 2;
            end
            p = $urandom_range(0, 99);
            half = (cpt_reg < 2) ? 1 : int'(cpt_reg) / 2;
            if (p < 40) begin
                if ($urandom_range(0, 9) == 0) delta = 16'($urandom());
                else delta = 16'($urandom_range(0, 2 * half + 4) - half - 2);
                send_item(OP_ROT, sent_raw + delta);
            end else if (p < 70) begin
                send_item(OP_TICK, 16'($urandom()));
            end else if (p < 93) begin
                send_item(OP_STEER, 16'($urandom()));
            end else if (p < 96) begin
                send_item(OP_RESTART, 16'($urandom()));
            end else begin
                send_item(OP_ROT, 16'($urandom()));
            end
            n++;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_STEER;
        in_ch.count = '0;
        out_ch.ready = 1'b1;
        err_cnt = 0;
        cycle_cnt = 0;
        stall_left = 0;
        busy_src = 1'b0;
        sent_raw = '0;
        cpt_reg = CPT_RESET;
        travel_reg = '0;
        inv_wb_reg = IWB_RESET;
        steer_st = '0;
        last_raw_st = '0;
        seeded_st = 1'b0;
        total_st = '0;
        total_tick_st = '0;
        x_st = '0;
        y_st = '0;
        yaw_st = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_unseeded_and_steer();
        test_unwrap_and_tick();
        test_small_turn_counts();
        test_random_drive(1250);
        drain();
        if (err_cnt == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
